// ===== sv/b64d_pkg.sv =====
`default_nettype none

package b64d_pkg;

	localparam logic        KIND_DATA     = 1'b0;
	localparam logic        KIND_STATUS   = 1'b1;
	localparam logic [7:0]  CHAR_PAD      = 8'h3D;
	localparam logic [7:0]  CHAR_CR       = 8'h0D;
	localparam logic [7:0]  CHAR_LF       = 8'h0A;
	localparam logic [7:0]  CHAR_SPACE    = 8'h20;
	localparam logic [7:0]  CHAR_TAB      = 8'h09;
	localparam logic [23:0] COUNT_OUT_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic        bad_char_seen;
		logic [23:0] decoded_count;
		logic        final_result;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  ndata;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic        status;
		logic        bad;
		logic [23:0] count;
	} job_t;

	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			return {1'b1, d[5:0]};
		end
		if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
			return {1'b1, d[5:0]};
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd52;
			return {1'b1, d[5:0]};
		end
		if (c == 8'h2B) return {1'b1, 6'd62};
		if (c == 8'h2F) return {1'b1, 6'd63};
		return 7'd0;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CHAR_CR || c == CHAR_LF || c == CHAR_SPACE || c == CHAR_TAB;
	endfunction

	function automatic logic [2:0] job_results(input job_t j);
		return {1'b0, j.ndata} + {2'b00, j.status};
	endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_front.sv =====
`default_nettype none

module b64d_front
	import b64d_pkg::*;
#(
	parameter int COUNT_BITS = 24
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t text,
	input  wire logic     push,
	output logic          full,
	output job_t          job,
	output logic          job_push,
	input  wire logic     queue_full
);

	localparam int CW = (COUNT_BITS > 24) ? COUNT_BITS : 24;

	logic [5:0]            store_q [3];
	logic [2:0]            pads_q;
	logic [1:0]            slots_q;
	logic                  err_q;
	logic                  stop_q;
	logic [COUNT_BITS-1:0] cnt_q;

	logic                  acc;
	logic [6:0]            sx;
	logic                  is_pad;
	logic [5:0]            v;
	logic [3:0]            pads;
	logic                  take;
	logic                  close_grp;
	logic [1:0]            ndata;
	logic                  stop_next;
	logic                  err_next;
	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS-1:0] cnt_next;
	logic [CW-1:0]         cnt_wide;

	assign full = queue_full;
	assign acc  = push && !queue_full;

	assign sx        = sextet_of(text.in_byte);
	assign is_pad    = text.in_byte == CHAR_PAD;
	assign v         = is_pad ? 6'd0 : sx[5:0];
	assign take      = !stop_q && (sx[6] || is_pad);
	assign close_grp = take && slots_q == 2'd3;
	assign pads      = {is_pad, pads_q};

	always_comb begin
		ndata     = 2'd0;
		stop_next = stop_q;
		if (close_grp) begin
			stop_next = 1'b1;
			case (pads)
				4'b0000: begin
					ndata     = 2'd3;
					stop_next = 1'b0;
				end
				4'b1000: ndata = 2'd2;
				4'b1100: ndata = 2'd1;
				default: ndata = 2'd0;
			endcase
		end
	end

	assign err_next = err_q || (!stop_q && !sx[6] && !is_pad && !is_blank(text.in_byte));

	assign sum      = {1'b0, cnt_q} + (COUNT_BITS + 1)'(ndata);
	assign cnt_next = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
	assign cnt_wide = CW'(cnt_next);

	always_comb begin
		job.ndata  = ndata;
		job.b1     = {store_q[0], store_q[1][5:4]};
		job.b2     = {store_q[1][3:0], store_q[2][5:2]};
		job.b3     = {store_q[2][1:0], v};
		job.status = text.end_of_text;
		job.bad    = err_next;
		job.count  = (cnt_wide > CW'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX : cnt_wide[23:0];
	end

	assign job_push = acc && (ndata != 2'd0 || text.end_of_text);

	always_ff @(posedge clk) begin
		if (acc && take && slots_q != 2'd3) begin
			store_q[slots_q] <= v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pads_q  <= '0;
			slots_q <= '0;
			err_q   <= 1'b0;
			stop_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (acc) begin
			if (text.end_of_text) begin
				pads_q  <= '0;
				slots_q <= '0;
				err_q   <= 1'b0;
				stop_q  <= 1'b0;
				cnt_q   <= '0;
			end else begin
				err_q  <= err_next;
				stop_q <= stop_next;
				cnt_q  <= cnt_next;
				if (close_grp) begin
					pads_q  <= '0;
					slots_q <= '0;
				end else if (take) begin
					pads_q  <= pads_q | (is_pad ? (3'b001 << slots_q) : 3'b000);
					slots_q <= slots_q + 2'd1;
				end
			end
		end
	end

	a_clear_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		acc && text.end_of_text |=> slots_q == 2'd0 && !stop_q && !err_q && cnt_q == '0)
		else $error("state not cleared after end of text");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q && !(acc && text.end_of_text) |=> stop_q && $stable(err_q))
		else $error("stopped decoder changed state");

endmodule

`default_nettype wire

// ===== sv/b64d_queue.sv =====
`default_nettype none

module b64d_queue
	import b64d_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t wr_job,
	input  wire logic wr_en,
	output logic      q_full,
	output job_t      rd_job,
	output logic      q_nempty,
	input  wire logic rd_en
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full   = cnt_q == NW'(DEPTH);
	assign q_nempty = cnt_q != '0;
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && q_nempty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + NW'(do_wr) - NW'(do_rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && q_full) && cnt_q <= NW'(DEPTH))
		else $error("job queue overflow");

endmodule

`default_nettype wire

// ===== sv/b64d_back.sv =====
`default_nettype none

module b64d_back
	import b64d_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t head,
	input  wire logic head_valid,
	output logic      head_pop,
	output out_item_t result,
	output logic      empty,
	input  wire logic pop
);

	job_t       cur_q;
	logic       cur_v_q;
	logic [2:0] idx_q;
	logic [2:0] nres;
	logic       last_res;
	logic       take_res;
	logic       load;

	assign nres     = job_results(cur_q);
	assign last_res = idx_q == nres - 3'd1;
	assign empty    = !cur_v_q;
	assign take_res = pop && cur_v_q;
	assign load     = !cur_v_q || (take_res && last_res);
	assign head_pop = load && head_valid;

	always_comb begin
		result.final_result = last_res;
		if (cur_q.status && last_res) begin
			result.kind          = KIND_STATUS;
			result.data_byte     = 8'h00;
			result.bad_char_seen = cur_q.bad;
			result.decoded_count = cur_q.count;
		end else begin
			result.kind          = KIND_DATA;
			result.bad_char_seen = 1'b0;
			result.decoded_count = 24'd0;
			case (idx_q)
				3'd0:    result.data_byte = cur_q.b1;
				3'd1:    result.data_byte = cur_q.b2;
				default: result.data_byte = cur_q.b3;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			cur_v_q <= head_valid;
			idx_q   <= '0;
		end else if (take_res) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> idx_q < nres)
		else $error("result index past end of job");

endmodule

`default_nettype wire

// ===== sv/base64_tolerant_decoder.sv =====
// channel  | handshake          | payload              | accepted when
// ---------+--------------------+----------------------+------------------
// input    | push / full        | text   (in_item_t)   | push && !full
// result   | empty / pop        | result (out_item_t)  | pop && !empty
//
// One text item is taken per cycle while the job queue has room.
// The result side hands out one item per cycle while pop is held; a full group
// gives three data items over four text items, so a steady stream is not
// slowed by the result port. Only result stalls or end-of-text items with up to
// four results fill the queue, and full then holds the input.
// A result reaches the ports through a queue write and then a job register load
// and may wait in the queue behind earlier jobs. Reset clears all control state.
// Either side may stall on its own; the queue holds up to QUEUE_DEPTH jobs.
`default_nettype none

module base64_tolerant_decoder
	import b64d_pkg::*;
#(
	parameter int COUNT_BITS  = 24,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t text,
	input  wire logic     push,
	output logic          full,
	output out_item_t     result,
	output logic          empty,
	input  wire logic     pop
);

	job_t fr_job;
	logic fr_push;
	logic q_full;
	job_t q_head;
	logic q_nempty;
	logic q_pop;

	b64d_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.push      (push),
		.full      (full),
		.job       (fr_job),
		.job_push  (fr_push),
		.queue_full(q_full)
	);

	b64d_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_job  (fr_job),
		.wr_en   (fr_push),
		.q_full  (q_full),
		.rd_job  (q_head),
		.q_nempty(q_nempty),
		.rd_en   (q_pop)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.head_valid(q_nempty),
		.head_pop  (q_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire
